// File: hw/rtl/irt3pl_pkg.sv
// Shared constants and table-building functions for the 3PL probability pipeline.
`default_nettype none

package irt3pl_pkg;

   // Stream payload widths
   localparam int REQ_DATA_W = 64;   // theta, discrimination, difficulty, guessing
   localparam int RSP_DATA_W = 16;   // probability
   localparam int FIELD_W    = 16;

   // Parameter defaults
   localparam int DEF_TABLE_DEPTH = 256;
   localparam int DEF_FRAC_BITS   = 12;

   // 1.0 in Q0.16 and in Q31
   localparam logic [16:0] ONE_Q16 = 17'd65536;
   localparam longint      ONE_Q31 = 64'sd2147483648;

   // Number of register stages in the datapath
   localparam int NUM_STAGES = 8;

   // Shift-subtract quotient of two non-negative values. Elaboration only.
   function automatic longint div_pos(input longint num, input longint den);
      longint q;
      longint r;
      begin
         q = 0;
         r = 0;
         for (int i = 63; i >= 0; i--) begin
            r = (r <<< 1) | ((num >>> i) & 64'sd1);
            if (r >= den) begin
               r = r - den;
               q = q | (64'sd1 <<< i);
            end
         end
         return q;
      end
   endfunction

   // e^-y for y in Q31 (y <= 0.5): 20-term series, then squared five times,
   // which gives e^-(32*y). Elaboration only.
   function automatic longint exp_q31(input longint y);
      longint sum;
      longint term;
      begin
         sum  = ONE_Q31;
         term = ONE_Q31;
         for (int n = 1; n <= 20; n++) begin
            term = div_pos((term * y) >>> 31, longint'(n));
            if (n[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         if (sum < 0) begin
            sum = 0;
         end
         if (sum > ONE_Q31) begin
            sum = ONE_Q31;
         end
         for (int n = 0; n < 5; n++) begin
            sum = (sum * sum) >>> 31;
         end
         return sum;
      end
   endfunction

endpackage

`default_nettype wire

// File: hw/rtl/irt_3pl_probability.sv
// Three-parameter logistic IRT probability, fully pipelined stream datapath.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------------------
//  req     | in        | req_tvalid/req_tready | tdata: theta, discrimination, difficulty,
//          |           |                       |        guessing; tlast: last_in
//  rsp     | out       | rsp_tvalid/rsp_tready | tdata: probability; tlast: last_out
//
//  One transaction enters per cycle unless a stall on rsp has backed up to req; each
//  result passes through the register stages in order: subtract, multiply, clamp,
//  scale, table read, interpolate multiply, sign fold, guessing blend.
//  Synchronous active-high reset clears only the stage valid bits.
//  Each stage advances when it is empty or the stage after it advances, so
//  bubbles collapse and a stall on rsp backs up stage by stage without loss.
//  The sigmoid table is a constant array computed at elaboration.
`default_nettype none

module irt_3pl_probability #(
   parameter int SIGMOID_TABLE_DEPTH = irt3pl_pkg::DEF_TABLE_DEPTH,
   parameter int FRAC_BITS           = irt3pl_pkg::DEF_FRAC_BITS
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // req_tdata, low to high: theta[15:0], discrimination[31:16],
   //                         difficulty[47:32], guessing[63:48]
   input  wire logic                              req_tvalid,
   output      logic                              req_tready,
   input  wire logic [irt3pl_pkg::REQ_DATA_W-1:0] req_tdata,
   input  wire logic                              req_tlast,    // last_in
   // rsp_tdata, low to high: probability[15:0]
   output      logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   output      logic [irt3pl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic                              rsp_tlast     // last_out
);

   import irt3pl_pkg::*;

   localparam int NS   = NUM_STAGES;
   localparam int DW   = $clog2(SIGMOID_TABLE_DEPTH + 1);  // table index bits
   localparam int SH   = FRAC_BITS + 4;                    // log2 of the 16.0 span
   localparam int MW   = SH + 1;                           // clamped |z| bits
   localparam int TW   = MW + DW;                          // |z| * depth bits
   localparam int PW   = 18 + SH + 1;                      // interpolation product
   localparam logic [31:0]  SPAN  = 32'(1) << SH;
   localparam logic [PW-1:0] RMASK = PW'((64'd1 << SH) - 64'd1);

   // ---------------------------------------------------------------------------
   // Sigmoid table, entry k for x = 16*k/depth, Q0.16
   // ---------------------------------------------------------------------------
   logic [16:0] sig_rom [0:SIGMOID_TABLE_DEPTH];

   for (genvar k = 0; k <= SIGMOID_TABLE_DEPTH; k++) begin : g_rom
      localparam longint Y     = (longint'(k) <<< 30) / SIGMOID_TABLE_DEPTH;
      localparam longint E     = exp_q31(Y);
      localparam longint Entry = (64'sd1 <<< 47) / (ONE_Q31 + E);
      assign sig_rom[k] = 17'(Entry);
   end

   // ---------------------------------------------------------------------------
   // Stage flow control
   // ---------------------------------------------------------------------------
   logic [NS-1:0] vld_ff;
   logic [NS-1:0] stage_en;

   always_comb begin
      stage_en[NS-1] = !vld_ff[NS-1] || rsp_tready;
      for (int i = NS - 2; i >= 0; i--) begin
         stage_en[i] = !vld_ff[i] || stage_en[i+1];
      end
   end

   assign req_tready = stage_en[0];

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         if (stage_en[0]) begin
            vld_ff[0] <= req_tvalid;
         end
         for (int i = 1; i < NS; i++) begin
            if (stage_en[i]) begin
               vld_ff[i] <= vld_ff[i-1];
            end
         end
      end
   end

   // Guessing and last travel alongside every stage
   logic [FIELD_W-1:0] c_ff    [NS];
   logic               last_ff [NS];

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         c_ff[0]    <= req_tdata[63:48];
         last_ff[0] <= req_tlast;
      end
      for (int i = 1; i < NS; i++) begin
         if (stage_en[i]) begin
            c_ff[i]    <= c_ff[i-1];
            last_ff[i] <= last_ff[i-1];
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 0: d = theta - b
   // ---------------------------------------------------------------------------
   logic signed [16:0]  d_in, d_ff;
   logic [FIELD_W-1:0]  a_ff;

   assign d_in = 17'($signed(req_tdata[15:0])) - 17'($signed(req_tdata[47:32]));

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         d_ff <= d_in;
         a_ff <= req_tdata[31:16];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 1: p = a * d
   // ---------------------------------------------------------------------------
   logic signed [32:0] p_in, p_ff;

   assign p_in = $signed({1'b0, a_ff}) * d_ff;

   always_ff @(posedge clock) begin
      if (stage_en[1]) begin
         p_ff <= p_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 2: |z| = |p| >> frac, clamped to 16.0; keep the sign
   // ---------------------------------------------------------------------------
   logic [31:0]   pabs;
   logic [31:0]   mag_full;
   logic [MW-1:0] mag_in, mag_ff;
   logic          neg2_ff, neg3_ff, neg4_ff, neg5_ff;

   assign pabs     = p_ff[32] ? 32'(-p_ff) : 32'(p_ff);
   assign mag_full = pabs >> FRAC_BITS;
   assign mag_in   = (mag_full > SPAN) ? MW'(SPAN) : MW'(mag_full);

   always_ff @(posedge clock) begin
      if (stage_en[2]) begin
         mag_ff  <= mag_in;
         neg2_ff <= p_ff[32];
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 3: t = |z| * depth, split into table index and fraction
   // ---------------------------------------------------------------------------
   logic [TW-1:0] t_w;
   logic [DW-1:0] idx_in, idx_ff;
   logic [SH-1:0] rem_in, rem3_ff;

   assign t_w    = TW'(mag_ff) * TW'(SIGMOID_TABLE_DEPTH);
   assign idx_in = t_w[SH +: DW];
   assign rem_in = t_w[SH-1:0];

   always_ff @(posedge clock) begin
      if (stage_en[3]) begin
         idx_ff  <= idx_in;
         rem3_ff <= rem_in;
         neg3_ff <= neg2_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 4: read the two neighboring table points (top entry repeats itself)
   // ---------------------------------------------------------------------------
   logic [DW-1:0] idx_hi;
   logic [16:0]   lo_ff, hi_ff;
   logic [SH-1:0] rem4_ff;

   assign idx_hi = (idx_ff == DW'(SIGMOID_TABLE_DEPTH)) ? idx_ff : idx_ff + 1'b1;

   always_ff @(posedge clock) begin
      if (stage_en[4]) begin
         lo_ff   <= sig_rom[idx_ff];
         hi_ff   <= sig_rom[idx_hi];
         rem4_ff <= rem3_ff;
         neg4_ff <= neg3_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 5: (hi - lo) * fraction
   // ---------------------------------------------------------------------------
   logic signed [17:0]   diff;
   logic signed [PW-1:0] prod_in, prod_ff;
   logic [16:0]          lo5_ff;

   assign diff    = $signed({1'b0, hi_ff}) - $signed({1'b0, lo_ff});
   assign prod_in = diff * $signed({1'b0, rem4_ff});

   always_ff @(posedge clock) begin
      if (stage_en[5]) begin
         prod_ff <= prod_in;
         lo5_ff  <= lo_ff;
         neg5_ff <= neg4_ff;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 6: s = lo + step/span (toward zero), clamp, fold negative side
   // ---------------------------------------------------------------------------
   logic signed [PW-1:0] prod_b;
   logic signed [18:0]   q_w;
   logic signed [18:0]   s_w;
   logic [16:0]          s_clamp;
   logic [16:0]          sig_in, sig_ff;

   assign prod_b = prod_ff + $signed(prod_ff[PW-1] ? RMASK : PW'(0));
   assign q_w    = 19'(prod_b >>> SH);
   assign s_w    = $signed({2'b00, lo5_ff}) + q_w;

   always_comb begin
      if (s_w < 0) begin
         s_clamp = '0;
      end else if (s_w > $signed({2'b00, ONE_Q16})) begin
         s_clamp = ONE_Q16;
      end else begin
         s_clamp = 17'(s_w);
      end
   end

   assign sig_in = neg5_ff ? (ONE_Q16 - s_clamp) : s_clamp;

   always_ff @(posedge clock) begin
      if (stage_en[6]) begin
         sig_ff <= sig_in;
      end
   end

   // ---------------------------------------------------------------------------
   // Stage 7: P = c + (1 - c) * sig, saturated
   // ---------------------------------------------------------------------------
   logic [33:0]         blend;
   logic [18:0]         psum;
   logic [FIELD_W-1:0]  prob_in, prob_ff;

   assign blend   = (ONE_Q16 - {1'b0, c_ff[6]}) * sig_ff;
   assign psum    = 19'(c_ff[6]) + 19'(blend[33:16]);
   assign prob_in = (psum > 19'(16'hFFFF)) ? 16'hFFFF : psum[15:0];

   always_ff @(posedge clock) begin
      if (stage_en[7]) begin
         prob_ff <= prob_in;
      end
   end

   assign rsp_tvalid = vld_ff[NS-1];
   assign rsp_tdata  = prob_ff;
   assign rsp_tlast  = last_ff[NS-1];

endmodule

`default_nettype wire

// File: hw/rtl/irt3pl_checker.sv
// Port-level checks for the 3PL probability block, bound to its top level.
`default_nettype none

module irt3pl_checker (
   input wire logic                              clock,
   input wire logic                              reset,
   input wire logic                              req_tready,
   input wire logic                              rsp_tvalid,
   input wire logic                              rsp_tready,
   input wire logic [irt3pl_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic                              rsp_tlast
);

   import irt3pl_pkg::*;

   // Reset empties the pipeline
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("rsp_tvalid high after reset");

   // Input backpressure only comes from a stalled, full output
   a_ready_cause: assert property (@(posedge clock) disable iff (reset)
      !req_tready |-> (rsp_tvalid && !rsp_tready))
      else $error("req_tready low without output stall");

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready) |=>
         (rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast)))
      else $error("rsp transaction changed while stalled");

   // A full pipeline behind a stalled output cannot start accepting while the output stays stalled
   a_stall_no_take: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tready && !req_tready) |=> !(req_tready && !rsp_tready))
      else $error("req_tready rose while output still stalled");

endmodule

bind irt_3pl_probability irt3pl_checker u_irt3pl_checker (.*);

`default_nettype wire

// File: tb/irt_3pl_probability_checker.sv
// Stream checker for the 3PL probability block: predicts each response and compares.
`timescale 1ns / 100ps

module irt_3pl_probability_checker (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   input  wire logic                              req_tready,
   input  wire logic [irt3pl_pkg::REQ_DATA_W-1:0] req_tdata,    // theta, a, b, c
   input  wire logic                              req_tlast,    // last_in
   input  wire logic                              rsp_tvalid,
   input  wire logic                              rsp_tready,
   input  wire logic [irt3pl_pkg::RSP_DATA_W-1:0] rsp_tdata,    // probability
   input  wire logic                              rsp_tlast,    // last_out
   output int                                     errors,
   output int                                     pending
);

   localparam int DEPTH = irt3pl_pkg::DEF_TABLE_DEPTH;
   localparam int FRAC  = irt3pl_pkg::DEF_FRAC_BITS;

   typedef struct packed {
      logic [15:0] probability;
      logic        last;
   } response_type;

   response_type expected_rsp[$];
   longint       logistic_rom [0:DEPTH];

   // 1/(1+e^-x) in Q0.16 at x = 16*k/DEPTH; e^-x from a series at x/32, squared 5 times
   function automatic longint logistic_point(int k);
      longint unity;
      longint y;
      longint acc;
      longint term;
      unity = irt3pl_pkg::ONE_Q31;
      y     = (longint'(k) <<< 30) / DEPTH;
      acc   = unity;
      term  = unity;
      for (int n = 1; n <= 20; n++) begin
         term = ((term * y) >>> 31) / longint'(n);
         if (n % 2 == 1) begin
            acc = acc - term;
         end else begin
            acc = acc + term;
         end
      end
      if (acc < 0) acc = 0;
      if (acc > unity) acc = unity;
      for (int n = 0; n < 5; n++) begin
         acc = (acc * acc) >>> 31;
      end
      return (64'sd1 <<< 47) / (unity + acc);
   endfunction

   function automatic response_type guessed_logistic(logic [63:0] data, logic last);
      logic signed [15:0] theta;
      logic signed [15:0] b;
      logic        [15:0] a;
      logic        [15:0] c;
      longint d, p, mag, span, t, idx, rem, s, sig, prob;
      response_type r;
      theta = data[15:0];
      a     = data[31:16];
      b     = data[47:32];
      c     = data[63:48];
      d     = longint'(theta) - longint'(b);
      p     = longint'(a) * d;
      mag   = (p < 0 ? -p : p) >>> FRAC;
      span  = longint'(16) <<< FRAC;
      if (mag > span) mag = span;   // argument clamped at 16.0
      t   = mag * DEPTH;
      idx = t / span;
      rem = t % span;
      if (idx >= DEPTH) begin
         s = logistic_rom[DEPTH];
      end else begin
         s = logistic_rom[int'(idx)] +
             ((logistic_rom[int'(idx) + 1] - logistic_rom[int'(idx)]) * rem) / span;
      end
      if (s < 0) s = 0;
      if (s > 65536) s = 65536;
      sig  = (p < 0) ? 65536 - s : s;   // sigmoid(-z) = 1 - sigmoid(z)
      prob = longint'(c) + (((65536 - longint'(c)) * sig) >>> 16);
      if (prob > 65535) prob = 65535;
      r.probability = prob[15:0];
      r.last        = last;
      return r;
   endfunction

   initial begin
      for (int k = 0; k <= DEPTH; k++) begin
         logistic_rom[k] = logistic_point(k);
      end
   end

   always @(posedge clock) begin : watch
      response_type want;
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (expected_rsp.size() == 0) begin
               errors++;
               $display("%0t: unexpected response: expected none, actual prob=%h last=%b",
                        $time, rsp_tdata, rsp_tlast);
            end else begin
               want = expected_rsp.pop_front();
               if (rsp_tdata !== want.probability) begin
                  errors++;
                  $display("%0t: probability mismatch: expected %h, actual %h",
                           $time, want.probability, rsp_tdata);
               end
               if (rsp_tlast !== want.last) begin
                  errors++;
                  $display("%0t: last_out mismatch: expected %b, actual %b",
                           $time, want.last, rsp_tlast);
               end
            end
         end
         if (req_tvalid && req_tready) begin
            expected_rsp.push_back(guessed_logistic(req_tdata, req_tlast));
         end
      end
      pending <= expected_rsp.size();
   end

endmodule

// File: tb/irt_3pl_probability_tb.sv
// Top of the 3PL probability testbench: clock, reset, request and response traffic, verdict.
`timescale 1ns / 100ps

module irt_3pl_probability_tb;

   localparam int  ITEM_TARGET  = 1950;
   localparam int  CYCLE_LIMIT  = 1000000;
   localparam int  HOLD_CYCLES  = 300;     // long receiver stall
   localparam int  HOLD_AT_ITEM = 600;
   localparam int  PAUSE_AT     = 1200;

   // which input field a random value is drawn for
   typedef enum int {FIELD_ABILITY, FIELD_SLOPE, FIELD_GUESS} field_kind_type;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [63:0] req_tdata  = '0;     // theta[15:0], a[31:16], b[47:32], c[63:48]
   logic        req_tlast  = 1'b0;   // last_in
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;           // probability[15:0]
   logic        rsp_tlast;           // last_out

   logic quiet    = 1'b0;   // both sides run without gaps
   logic hold_off = 1'b0;   // asks the receiver for one long stall
   int   errors;
   int   pending;
   int   sent      = 0;
   int   cycles    = 0;
   int   rsp_gap   = 0;
   int   hold_count = 0;
   bit   hold_done = 1'b0;

   irt_3pl_probability uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

   irt_3pl_probability_checker checker_i (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .errors     (errors),
      .pending    (pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   // watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles >= CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Receiver: random back-pressure, mostly short gaps, a few long ones,
   // plus the one long hold-off counted here while the sender keeps offering.
   always @(posedge clock) begin : receiver
      int r;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_off && !hold_done) begin
         rsp_tready <= 1'b0;
         hold_count++;
         if (hold_count >= HOLD_CYCLES) hold_done = 1'b1;
      end else if (quiet) begin
         rsp_tready <= 1'b1;
      end else if (rsp_gap > 0) begin
         rsp_tready <= 1'b0;
         rsp_gap--;
      end else begin
         rsp_tready <= 1'b1;
         r = $urandom_range(0, 99);
         if (r < 25) begin
            rsp_gap = $urandom_range(1, 3);
         end else if (r < 28) begin
            rsp_gap = $urandom_range(15, 50);
         end
      end
   end

   // Draw a field value: extremes, full-range noise, or a typical operating value.
   function automatic logic [15:0] pick_field(field_kind_type kind);
      int r;
      r = $urandom_range(0, 19);
      case (kind)
         FIELD_ABILITY: begin
            if (r < 2) begin
               case ($urandom_range(0, 3))
                  0: return 16'h8000;
                  1: return 16'h7FFF;
                  2: return 16'h0000;
                  default: return 16'hFFFF;
               endcase
            end
            if (r < 7) return 16'($urandom);
            return 16'($urandom_range(0, 32768) - 16384);   // within +-4.0
         end
         FIELD_SLOPE: begin
            if (r < 2) begin
               case ($urandom_range(0, 3))
                  0: return 16'h0000;
                  1: return 16'hFFFF;
                  2: return 16'h0001;
                  default: return 16'h1000;
               endcase
            end
            if (r < 6) return 16'($urandom);
            return 16'($urandom_range(1024, 12288));        // 0.25 .. 3.0
         end
         default: begin
            if (r < 2) begin
               case ($urandom_range(0, 2))
                  0: return 16'h0000;
                  1: return 16'hFFFF;
                  default: return 16'h0001;
               endcase
            end
            if (r < 6) return 16'($urandom);
            return 16'($urandom_range(0, 16'h4CCC));        // up to about 0.3
         end
      endcase
   endfunction

   // One request transaction; valid stays high across back-to-back items.
   task automatic send_pair(input logic [15:0] theta, input logic [15:0] a,
                            input logic [15:0] b, input logic [15:0] c, input logic last);
      int gap;
      int r;
      req_tdata  <= {c, b, a, theta};
      req_tlast  <= last;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      sent++;
      gap = 0;
      if (!quiet) begin
         r = $urandom_range(0, 99);
         if (r >= 90) begin
            gap = $urandom_range(10, 40);
         end else if (r >= 55) begin
            gap = $urandom_range(1, 3);
         end
      end
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // Stop offering and wait for every outstanding response.
   // pending is registered, so it is read only after its register has taken in the last transaction.
   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (pending != 0) @(posedge clock);
   endtask

   initial begin : stimulus
      logic [15:0] theta;
      int          sweep_len;
      bit          noisy_last;
      bit          hold_started;
      hold_started = 1'b0;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed: zero slope, both argument extremes, exact clamp point,
      // full scale, sign near zero, guessing extremes, last flag both ways
      send_pair(16'h0000, 16'h0000, 16'h0000, 16'h0000, 1'b0);
      send_pair(16'h7FFF, 16'h0000, 16'h8000, 16'hFFFF, 1'b1);
      send_pair(16'h7FFF, 16'hFFFF, 16'h8000, 16'h0000, 1'b0);
      send_pair(16'h8000, 16'hFFFF, 16'h7FFF, 16'h0000, 1'b1);
      send_pair(16'h8000, 16'hFFFF, 16'h7FFF, 16'hFFFF, 1'b0);
      send_pair(16'h7FFF, 16'hFFFF, 16'h8000, 16'hFFFF, 1'b1);
      send_pair(16'h4000, 16'h2000, 16'hC000, 16'h0000, 1'b0);   // z = +16.0 exactly
      send_pair(16'h3FFF, 16'h2000, 16'hC000, 16'h0000, 1'b0);   // just under the clamp
      send_pair(16'hC000, 16'h2000, 16'h4000, 16'h8000, 1'b1);   // z = -16.0 exactly
      send_pair(16'h1000, 16'h1000, 16'h0000, 16'h0000, 1'b0);
      send_pair(16'h0001, 16'h1000, 16'h0000, 16'h0000, 1'b0);
      send_pair(16'h0000, 16'h0001, 16'h0001, 16'h0000, 1'b0);   // tiny negative product
      send_pair(16'h0800, 16'h1800, 16'hF800, 16'h2000, 1'b1);
      send_pair(16'h1234, 16'h0000, 16'h1234, 16'h0001, 1'b0);
      send_pair(16'hFFFF, 16'h0001, 16'h0000, 16'hFFFE, 1'b0);
      send_pair(16'h8000, 16'hFFFF, 16'h8000, 16'h7FFF, 1'b1);   // theta equals b
      send_pair(16'h2000, 16'h0100, 16'hE000, 16'h4000, 1'b1);
      drain();

      // random sweeps: mostly one person against a run of items, last on the final pair (or random)
      while (sent < ITEM_TARGET) begin
         quiet      <= ($urandom_range(0, 5) == 0);
         noisy_last  = ($urandom_range(0, 9) == 0);
         sweep_len   = $urandom_range(1, 12);
         theta       = pick_field(FIELD_ABILITY);
         if (!hold_started && sent >= HOLD_AT_ITEM) begin
            // receiver stalls long while we keep offering back to back
            hold_started = 1'b1;
            hold_off    <= 1'b1;
            quiet       <= 1'b1;
            sweep_len    = 40;
         end
         for (int i = 0; i < sweep_len; i++) begin
            if ($urandom_range(0, 7) == 0) theta = pick_field(FIELD_ABILITY);
            send_pair(theta, pick_field(FIELD_SLOPE), pick_field(FIELD_ABILITY),
                      pick_field(FIELD_GUESS),
                      noisy_last ? 1'($urandom) : (i == sweep_len - 1));
         end
         if (sent >= PAUSE_AT && sent < PAUSE_AT + sweep_len) begin
            drain();
         end
      end

      quiet <= 1'b0;
      drain();
      repeat (4 * irt3pl_pkg::NUM_STAGES) @(posedge clock);
      if (errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

// File: sim.f
hw/rtl/irt3pl_pkg.sv
hw/rtl/irt_3pl_probability.sv
hw/rtl/irt3pl_checker.sv
tb/irt_3pl_probability_checker.sv
tb/irt_3pl_probability_tb.sv
